// File: hdl/stt_pkg.sv
// Shared types, command codes and constants for the system tick timekeeper.
// No dependencies; imported by every module of the block.
package stt_pkg;

  localparam int unsigned TOP_STATE   = 5;
  localparam int unsigned LAST_STATE  = 6;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [7:0]  TICK_PERIOD_RESET = 8'd10;
  localparam logic [7:0]  LED_PHASE_LIMIT   = 8'd10;
  localparam logic [15:0] MS_ROLLOVER       = 16'd60000;
  localparam logic [8:0]  SECOND_LIMIT      = 9'd100;
  localparam logic [7:0]  TENS_UNKNOWN      = 8'hff;
  localparam logic [15:0] PATTERN_RESET     = 16'hffff;

  // register index taken from paddr[2]
  localparam logic REG_TICK_PERIOD = 1'b0;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_SET_DELAY  = 3'd1,
    CMD_TAKE_RUN   = 3'd2,
    CMD_TAKE_SEC   = 3'd3,
    CMD_SET_STATE  = 3'd4,
    CMD_LOAD_TIME  = 3'd5
  } cmd_t;

  typedef logic [15:0] pattern_tbl_t [LAST_STATE+1];

  localparam pattern_tbl_t PATTERN_TBL = '{
    16'hffff, 16'h3333, 16'h0000, 16'h0001, 16'h000f, 16'h00ff, 16'h00f7
  };

  typedef struct packed {
    logic        led;
    logic        run_flag;
    logic        second_flag;
    logic [15:0] delay_value;
    logic [7:0]  tens_minutes;
    logic [15:0] ms_count;
    logic [31:0] tick_total;
  } stt_result_t;

  // pattern for a state index, clamped to the top state
  function automatic logic [15:0] pattern_for(input logic [15:0] sel);
    logic [15:0] s;
    s = sel;
    if (s > 16'(TOP_STATE)) s = 16'(TOP_STATE);
    if (s > 16'(LAST_STATE)) s = 16'(LAST_STATE);
    return PATTERN_TBL[s[2:0]];
  endfunction

endpackage

// File: hdl/stt_engine.sv
// Timekeeping state and per-command update logic.
// Depends on stt_pkg; state advances on each transfer, result is combinational.
module stt_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [2:0]          cmd,
  input  logic [15:0]         value,
  input  logic [7:0]          tick_period,
  output stt_pkg::stt_result_t result
);
  import stt_pkg::*;

  logic [15:0] led_pattern, led_pattern_next;
  logic [7:0]  led_phase, led_phase_next;
  logic        led_level, led_level_next;
  logic [15:0] ms_accum, ms_accum_next;
  logic [7:0]  tens_count, tens_count_next;
  logic [15:0] main_countdown, main_countdown_next;
  logic [15:0] reload_delay, reload_delay_next;
  logic [8:0]  second_accum, second_accum_next;
  logic        run_pending, run_pending_next;
  logic        second_pending, second_pending_next;
  logic [31:0] total_ticks, total_ticks_next;

  logic [7:0]  phase_sum;
  logic [16:0] ms_sum;
  logic [15:0] cd_dec;
  logic [8:0]  sec_sum;

  assign phase_sum = led_phase + tick_period;
  assign ms_sum    = {1'b0, ms_accum} + {9'd0, tick_period};
  assign cd_dec    = main_countdown - 16'd1;
  assign sec_sum   = second_accum + {1'b0, tick_period};

  always_comb begin
    led_pattern_next     = led_pattern;
    led_phase_next       = led_phase;
    led_level_next       = led_level;
    ms_accum_next        = ms_accum;
    tens_count_next      = tens_count;
    main_countdown_next  = main_countdown;
    reload_delay_next    = reload_delay;
    second_accum_next    = second_accum;
    run_pending_next     = run_pending;
    second_pending_next  = second_pending;
    total_ticks_next     = total_ticks;

    unique case (cmd)
      CMD_TICK: begin
        led_phase_next = phase_sum;
        if (phase_sum > LED_PHASE_LIMIT) begin
          led_phase_next   = phase_sum - LED_PHASE_LIMIT;
          led_level_next   = led_pattern[15];
          led_pattern_next = {led_pattern[14:0], led_pattern[15]};
        end
        if (tens_count != TENS_UNKNOWN) begin
          if (ms_sum >= {1'b0, MS_ROLLOVER}) begin
            ms_accum_next   = '0;
            tens_count_next = tens_count + 8'd1;
          end else begin
            ms_accum_next = ms_sum[15:0];
          end
        end
        if (main_countdown != '0) begin
          main_countdown_next = cd_dec;
          if (cd_dec == '0) begin
            run_pending_next    = 1'b1;
            main_countdown_next = reload_delay;
          end
        end
        second_accum_next = sec_sum;
        if (sec_sum >= SECOND_LIMIT) begin
          second_accum_next   = sec_sum - SECOND_LIMIT;
          second_pending_next = 1'b1;
        end
        total_ticks_next = total_ticks + 32'd1;
      end
      CMD_SET_DELAY: begin
        reload_delay_next = value;
        if (main_countdown == '0) main_countdown_next = value;
      end
      CMD_TAKE_RUN:  run_pending_next = 1'b0;
      CMD_TAKE_SEC:  second_pending_next = 1'b0;
      CMD_SET_STATE: led_pattern_next = pattern_for(value);
      CMD_LOAD_TIME: begin
        tens_count_next = (value[15:8] != '0) ? TENS_UNKNOWN : value[7:0];
        ms_accum_next   = '0;
      end
      default: ;
    endcase
  end

  // taken flag reports its value before clearing
  always_comb begin
    result.led          = led_level_next;
    result.run_flag     = (cmd == CMD_TAKE_RUN) ? run_pending : run_pending_next;
    result.second_flag  = (cmd == CMD_TAKE_SEC) ? second_pending : second_pending_next;
    result.delay_value  = reload_delay_next;
    result.tens_minutes = tens_count_next;
    result.ms_count     = ms_accum_next;
    result.tick_total   = total_ticks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_pattern     <= PATTERN_RESET;
      led_phase       <= '0;
      led_level       <= 1'b0;
      ms_accum        <= '0;
      tens_count      <= TENS_UNKNOWN;
      main_countdown  <= '0;
      reload_delay    <= '0;
      second_accum    <= '0;
      run_pending     <= 1'b0;
      second_pending  <= 1'b0;
      total_ticks     <= '0;
    end else if (accept) begin
      led_pattern     <= led_pattern_next;
      led_phase       <= led_phase_next;
      led_level       <= led_level_next;
      ms_accum        <= ms_accum_next;
      tens_count      <= tens_count_next;
      main_countdown  <= main_countdown_next;
      reload_delay    <= reload_delay_next;
      second_accum    <= second_accum_next;
      run_pending     <= run_pending_next;
      second_pending  <= second_pending_next;
      total_ticks     <= total_ticks_next;
    end
  end

endmodule

// File: hdl/system_tick_timekeeper.sv
// System tick timekeeper top level: APB register, input handshake, result register.
// Depends on stt_pkg and stt_engine.
// Result valid in the cycle after the input transfer; throughput one item per cycle.
// The result register frees itself on the same edge it is taken, so input flows while
// output is not stalled; input stalls only while a held result is stalled.
// Synchronous active-high reset: tick_period = 10, all state to its reset value, no result.
module system_tick_timekeeper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [stt_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [stt_pkg::APB_DATA_W-1:0] pwdata,
  output logic [stt_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     cmd,
  input  logic [15:0]                    value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           led,
  output logic                           run_flag,
  output logic                           second_flag,
  output logic [15:0]                    delay_value,
  output logic [7:0]                     tens_minutes,
  output logic [15:0]                    ms_count,
  output logic [31:0]                    tick_total
);
  import stt_pkg::*;

  logic [7:0]  tick_period_q;
  logic        accept;
  logic        reg_hit;
  stt_result_t result;
  stt_result_t out_q;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_TICK_PERIOD);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_q <= TICK_PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tick_period_q <= pwdata[7:0];
    end
  end

  assign prdata = reg_hit ? {24'd0, tick_period_q} : '0;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  stt_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .cmd         (cmd),
    .value       (value),
    .tick_period (tick_period_q),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
    if (accept) out_q <= result;
  end

  assign led          = out_q.led;
  assign run_flag     = out_q.run_flag;
  assign second_flag  = out_q.second_flag;
  assign delay_value  = out_q.delay_value;
  assign tens_minutes = out_q.tens_minutes;
  assign ms_count     = out_q.ms_count;
  assign tick_total   = out_q.tick_total;

endmodule

// File: hdl/stt_checker.sv
// Port-level checks for system_tick_timekeeper, bound to the top level.
// Depends on stt_pkg.
module stt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [2:0]                     cmd,
  input logic [15:0]                    value,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [15:0]                    delay_value,
  input logic [7:0]                     tens_minutes,
  input logic [15:0]                    ms_count
);
  import stt_pkg::*;

  logic xfer;
  assign xfer = in_valid && !in_stall;

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    xfer |=> out_valid)
    else $error("transfer not followed by a result");

  a_delay_shown: assert property (@(posedge clk) disable iff (rst)
    xfer && cmd == CMD_SET_DELAY |=> delay_value == $past(value))
    else $error("set delay not reflected");

  a_load_clears_ms: assert property (@(posedge clk) disable iff (rst)
    xfer && cmd == CMD_LOAD_TIME |=> ms_count == '0 &&
      tens_minutes == (($past(value[15:8]) != '0) ? TENS_UNKNOWN : $past(value[7:0])))
    else $error("load time result wrong");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

endmodule

bind system_tick_timekeeper stt_checker u_stt_checker (.*);
